// File: hdl/u8d_pkg.sv
package u8d_pkg;

  localparam int ByteW  = 8;
  localparam int UnitW  = 21;
  localparam int MaxRes = 2;

  // output queue; must hold at least MaxRes entries beyond one draining slot
  localparam int QDepth = 4;

  // sequence length classes
  localparam logic [1:0] LenNone = 2'd0;
  localparam logic [1:0] Len2    = 2'd1;
  localparam logic [1:0] Len3    = 2'd2;
  localparam logic [1:0] Len4    = 2'd3;

  localparam logic [UnitW-1:0] MaxPoint  = 21'h10FFFF;
  localparam logic [UnitW-1:0] SurLo     = 21'h00D800;
  localparam logic [UnitW-1:0] SurHi     = 21'h00DFFF;
  localparam logic [UnitW-1:0] SuppBase  = 21'h010000;
  localparam logic [UnitW-1:0] Min2      = 21'h000080;
  localparam logic [UnitW-1:0] Min3      = 21'h000800;
  localparam logic [15:0]      HighSur   = 16'hD800;
  localparam logic [15:0]      LowSur    = 16'hDC00;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             buffer_last;
  } in_item_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             bad_input;
    logic             run_end;
    logic             buffer_end;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] count;
  } res_pair_t;

endpackage

// File: hdl/u8d_in_reg.sv
module u8d_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  u8d_pkg::in_item_t s_item,
  output logic              item_valid,
  output u8d_pkg::in_item_t item,
  input  logic              advance
);
  import u8d_pkg::*;

  logic take;

  assign s_ready = !item_valid || advance;
  assign take    = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= s_item;
    end
  end

endmodule

// File: hdl/u8d_decode.sv
module u8d_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_mode,
  input  logic               fire,
  input  u8d_pkg::in_item_t  item,
  output u8d_pkg::res_pair_t res
);
  import u8d_pkg::*;

  logic             utf16_mode;
  logic [UnitW-1:0] partial_point, partial_point_next;
  logic [1:0]       bytes_pending, bytes_pending_next;
  logic [1:0]       length_class, length_class_next;
  logic             skipping, skipping_next;

  logic             do_fail, do_emit;
  logic [UnitW-1:0] cp, folded, minimum;
  logic [1:0]       pend_dec;
  logic [19:0]      adj;
  logic [ByteW-1:0] b;
  logic             last;

  assign b        = item.byte_in;
  assign last     = item.buffer_last;
  assign folded   = {partial_point[UnitW-7:0], b[5:0]};
  assign pend_dec = bytes_pending - 2'd1;
  assign adj      = 20'(cp - SuppBase);

  always_comb begin
    case (length_class)
      Len2:    minimum = Min2;
      Len3:    minimum = Min3;
      Len4:    minimum = SuppBase;
      default: minimum = '0;
    endcase
  end

  always_comb begin
    partial_point_next = partial_point;
    bytes_pending_next = bytes_pending;
    length_class_next  = length_class;
    skipping_next      = skipping;
    do_fail            = 1'b0;
    do_emit            = 1'b0;
    cp                 = {{(UnitW-ByteW){1'b0}}, b};
    res                = '0;

    if (skipping) begin
      if (last) begin
        skipping_next = 1'b0;
      end
    end else if (bytes_pending == 2'd0) begin
      if (!b[7]) begin
        do_emit = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        partial_point_next = {{(UnitW-5){1'b0}}, b[4:0]};
        bytes_pending_next = 2'd1;
        length_class_next  = Len2;
        do_fail            = last;
      end else if (b[7:4] == 4'b1110) begin
        partial_point_next = {{(UnitW-4){1'b0}}, b[3:0]};
        bytes_pending_next = 2'd2;
        length_class_next  = Len3;
        do_fail            = last;
      end else if (b[7:3] == 5'b11110) begin
        partial_point_next = {{(UnitW-3){1'b0}}, b[2:0]};
        bytes_pending_next = 2'd3;
        length_class_next  = Len4;
        do_fail            = last;
      end else begin
        do_fail = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      do_fail = 1'b1;
    end else begin
      partial_point_next = folded;
      bytes_pending_next = pend_dec;
      if (pend_dec != 2'd0) begin
        do_fail = last;
      end else begin
        cp                 = folded;
        partial_point_next = '0;
        length_class_next  = LenNone;
        if (folded < minimum || folded > MaxPoint ||
            (folded >= SurLo && folded <= SurHi)) begin
          do_fail = 1'b1;
        end else begin
          do_emit = 1'b1;
        end
      end
    end

    if (do_fail) begin
      partial_point_next = '0;
      bytes_pending_next = 2'd0;
      length_class_next  = LenNone;
      skipping_next      = !last;
      res.r0             = '{code_unit: '0, bad_input: 1'b1, run_end: 1'b1, buffer_end: 1'b1};
      res.count          = 2'd1;
    end else if (do_emit) begin
      if (utf16_mode && cp >= SuppBase) begin
        res.r0 = '{code_unit: UnitW'(HighSur + 16'(adj[19:10])), bad_input: 1'b0,
                   run_end: 1'b0, buffer_end: 1'b0};
        res.r1 = '{code_unit: UnitW'(LowSur + 16'(adj[9:0])), bad_input: 1'b0,
                   run_end: 1'b1, buffer_end: last};
        res.count = 2'd2;
      end else begin
        res.r0    = '{code_unit: cp, bad_input: 1'b0, run_end: 1'b1, buffer_end: last};
        res.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_mode    <= 1'b0;
      partial_point <= '0;
      bytes_pending <= 2'd0;
      length_class  <= LenNone;
      skipping      <= 1'b0;
    end else begin
      if (cfg_we) begin
        utf16_mode <= cfg_mode;
      end
      if (fire) begin
        partial_point <= partial_point_next;
        bytes_pending <= bytes_pending_next;
        length_class  <= length_class_next;
        skipping      <= skipping_next;
      end
    end
  end

  // a sequence in flight always knows its length
  a_class_set : assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != 2'd0) |-> (length_class != LenNone))
    else $error("pending bytes without a length class");

  // while dropping bytes no sequence is held
  a_skip_clean : assert property (@(posedge clk) disable iff (rst)
    skipping |-> (bytes_pending == 2'd0 && length_class == LenNone))
    else $error("sequence state held while skipping");

  // an error on a non-final byte starts skipping
  a_skip_after_fail : assert property (@(posedge clk) disable iff (rst)
    (fire && res.count != 2'd0 && res.r0.bad_input && !last) |=> skipping)
    else $error("skipping not set after error");

endmodule

// File: hdl/u8d_out_fifo.sv
module u8d_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8d_pkg::res_pair_t res,
  output logic               room,
  output logic               m_valid,
  input  logic               m_ready,
  output u8d_pkg::res_t      m_res
);
  import u8d_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  res_t            mem [QDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [1:0]      n_in;

  assign pop     = m_valid && m_ready;
  assign n_in    = push ? res.count : 2'd0;
  assign room    = count <= CntW'(QDepth - MaxRes);
  assign m_valid = count != '0;
  assign m_res   = mem[rd_ptr];

  always_comb begin
    count_next = count + CntW'(n_in) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_in);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_ptr] <= res.r0;
    end
    if (n_in == 2'd2) begin
      mem[wr_ptr + PtrW'(1)] <= res.r1;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QDepth))
    else $error("output queue overflow");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    (n_in != 2'd0) |-> room)
    else $error("push without room");

  // first unit of a surrogate pair is always followed by its low unit
  a_pair_order : assert property (@(posedge clk) disable iff (rst)
    (n_in == 2'd2) |-> (!res.r0.run_end && res.r1.run_end))
    else $error("bad pair ordering");

endmodule

// File: hdl/utf8_validating_decoder_top.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata[7:0] byte_in, tlast buffer_last
// m_*       out  m_tvalid/m_tready    tdata[20:0] code_unit, tuser bad_input/run_end,
//                                     tlast buffer_end
// cfg_*     in   cfg_valid/cfg_ready  cfg_data utf16_mode
//
// One byte per cycle while the result queue has room: input register -> decode logic -> 4-entry result queue.
// A taken byte is held in the input register and decoded there; its results are pushed once the queue has room.
// A surrogate pair gives two output units; the queue takes both in a single push.
// s_tready drops only when the queue holds more than two results (m_tready stalled or pairs pile up).
// rst is synchronous; it clears the sequence state, skipping and the mode to 0.
module utf8_validating_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // buffer_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_unit, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] bad_input, [1] run_end
  output logic        m_tlast,   // buffer_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // utf16_mode
);
  import u8d_pkg::*;

  in_item_t  s_item, item;
  logic      item_valid, room, fire;
  res_pair_t res;
  res_t      m_res;

  assign s_item    = '{byte_in: s_tdata, buffer_last: s_tlast};
  assign fire      = item_valid && room;
  assign cfg_ready = 1'b1;

  u8d_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (fire)
  );

  u8d_decode u_dec (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_mode (cfg_data),
    .fire     (fire),
    .item     (item),
    .res      (res)
  );

  u8d_out_fifo u_q (
    .clk     (clk),
    .rst     (rst),
    .push    (fire),
    .res     (res),
    .room    (room),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  assign m_tdata = {3'b000, m_res.code_unit};
  assign m_tuser = {m_res.run_end, m_res.bad_input};
  assign m_tlast = m_res.buffer_end;

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] byte_in
  logic        s_tlast = 1'b0; // buffer_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [20:0] code_unit, [23:21] zero
  logic [1:0]  m_tuser;        // [0] bad_input, [1] run_end
  logic        m_tlast;        // buffer_end
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  utf8_validating_decoder_top DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // decoder state as predicted
  logic [UnitW-1:0] seq_bits = '0;
  logic [1:0]       seq_left = '0;
  logic [1:0]       seq_class = LenNone;
  logic             dropping = 1'b0;
  logic             utf16_on = 1'b0;

  in_item_t byte_q[$];
  res_t     units_due[$];
  int       n_pushed = 0;
  int       n_accepted = 0;
  int       mism_cnt = 0;
  int       cycle_cnt = 0;
  logic     in_took = 1'b0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       rx_hold = 0;
  bit       tx_idle_on = 1'b1;
  bit       rx_idle_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- predictor ----------------

  task automatic due_add(input res_t r);
    units_due.insert(units_due.size(), r);
  endtask

  task automatic give_point(input logic [UnitW-1:0] cp, input logic last);
    logic [UnitW-1:0] off;
    if (utf16_on && cp >= SuppBase) begin
      off = cp - SuppBase;
      due_add('{UnitW'(HighSur) + (off >> 10), 1'b0, 1'b0, 1'b0});
      due_add('{UnitW'(LowSur) + (off & 21'h3FF), 1'b0, 1'b1, last});
    end else begin
      due_add('{cp, 1'b0, 1'b1, last});
    end
  endtask

  task automatic reject_seq(input logic last);
    seq_bits = '0;
    seq_left = '0;
    seq_class = LenNone;
    dropping = !last;
    due_add('{'0, 1'b1, 1'b1, 1'b1});
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [UnitW-1:0] cp;
    logic [UnitW-1:0] floor_v;
    if (dropping) begin
      if (last) dropping = 1'b0;
      return;
    end
    if (seq_left == 0) begin
      if (!b[7]) begin
        give_point(UnitW'(b), last);
        return;
      end
      if (b[7:5] == 3'b110) begin
        seq_bits = UnitW'(b[4:0]);
        seq_left = 2'd1;
        seq_class = Len2;
      end else if (b[7:4] == 4'b1110) begin
        seq_bits = UnitW'(b[3:0]);
        seq_left = 2'd2;
        seq_class = Len3;
      end else if (b[7:3] == 5'b11110) begin
        seq_bits = UnitW'(b[2:0]);
        seq_left = 2'd3;
        seq_class = Len4;
      end else begin
        reject_seq(last);
        return;
      end
      // lead byte on the buffer's last position: sequence cut short
      if (last) reject_seq(last);
      return;
    end
    if (b[7:6] != 2'b10) begin
      reject_seq(last);
      return;
    end
    seq_bits = {seq_bits[14:0], b[5:0]};
    seq_left = seq_left - 2'd1;
    if (seq_left != 0) begin
      if (last) reject_seq(last);
      return;
    end
    cp = seq_bits;
    case (seq_class)
      Len2:    floor_v = Min2;
      Len3:    floor_v = Min3;
      Len4:    floor_v = SuppBase;
      default: floor_v = '0;
    endcase
    seq_bits = '0;
    seq_class = LenNone;
    if (cp < floor_v || cp > MaxPoint || (cp >= SurLo && cp <= SurHi)) reject_seq(last);
    else give_point(cp, last);
  endtask

  // ---------------- checking ----------------

  task automatic note_fault(input string why, input res_t want, input res_t got);
    mism_cnt++;
    if (mism_cnt <= 10) begin
      $display("%s at cycle %0d: want unit=%h bad=%b run_end=%b buf_end=%b", why,
               cycle_cnt, want.code_unit, want.bad_input, want.run_end, want.buffer_end);
      $display("    got unit=%h bad=%b run_end=%b buf_end=%b",
               got.code_unit, got.bad_input, got.run_end, got.buffer_end);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[UnitW-1:0], m_tuser[0], m_tuser[1], m_tlast};
        if (units_due.size() == 0) begin
          note_fault("unexpected result", '0, got);
        end else begin
          want = units_due.pop_front();
          if (got.code_unit !== want.code_unit || got.bad_input !== want.bad_input ||
              got.run_end !== want.run_end || got.buffer_end !== want.buffer_end)
            note_fault("wrong result", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        n_accepted++;
      end
      in_took <= s_tvalid && s_tready;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- byte sender and result receiver ----------------

  always @(negedge clk) begin
    in_item_t nxt;
    if (!rst && (!s_tvalid || in_took)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.byte_in;
        s_tlast <= nxt.buffer_last;
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  // ---------------- stimulus ----------------

  task automatic put_byte(input logic [7:0] b, input logic last);
    byte_q.insert(byte_q.size(), in_item_t'{b, last});
    n_pushed++;
  endtask

  // encode cp in n bytes (no range check), send the first keep of them
  task automatic put_seq(input logic [UnitW-1:0] cp, input int n, input int keep,
                         input logic last);
    logic [7:0] enc [4];
    case (n)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) put_byte(enc[i], last && (i == keep - 1));
  endtask

  task automatic put_good(input logic last);
    int n;
    logic [UnitW-1:0] cp;
    n = $urandom_range(1, 4);
    case (n)
      1: cp = $urandom_range(0, 'h7F);
      2: cp = $urandom_range('h80, 'h7FF);
      3: begin
        // skip over the surrogate block
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= SurLo) cp += 'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    put_seq(cp, n, n, last);
  endtask

  task automatic put_fault(input logic last);
    int n;
    int k;
    logic [7:0] b;
    case ($urandom_range(0, 6))
      0: begin  // overlong
        n = $urandom_range(2, 4);
        put_seq(n == 2 ? $urandom_range(0, 'h7F) : n == 3 ? $urandom_range(0, 'h7FF)
                : $urandom_range(0, 'hFFFF), n, n, last);
      end
      1: put_seq($urandom_range(SurLo, SurHi), 3, 3, last);
      2: put_seq($urandom_range('h110000, 'h1FFFFF), 4, 4, last);
      3: begin  // cut short
        n = $urandom_range(2, 4);
        put_seq($urandom_range('h10000, 'h10FFFF), n, $urandom_range(1, n - 1), last);
      end
      4: begin  // continuation byte with wrong top bits
        n = $urandom_range(2, 4);
        put_seq($urandom_range('h10000, 'h10FFFF), n, $urandom_range(1, n - 1), 1'b0);
        b = $urandom_range(0, 255);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        put_byte(b, last);
      end
      5: put_byte($urandom_range(0, 1) ? $urandom_range('h80, 'hBF)
                  : $urandom_range('hF8, 'hFF), last);
      default: begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) put_byte($urandom_range(0, 255), last && i == k - 1);
      end
    endcase
  endtask

  task automatic put_buffer();
    int pts;
    int bad_at;
    pts = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
    bad_at = ($urandom_range(0, 99) < 80) ? -1 : $urandom_range(0, pts - 1);
    for (int i = 0; i < pts; i++) begin
      if (i == bad_at) put_fault(i == pts - 1);
      else put_good(i == pts - 1);
    end
  endtask

  task automatic put_random(input int count);
    int base;
    base = n_pushed;
    while (n_pushed - base < count) put_buffer();
  endtask

  // everything sent and answered, then idle so that bytes that give no result drain too
  task automatic settle();
    while (n_accepted != n_pushed || units_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mode(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    utf16_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // code point mode after reset
    put_byte(8'h00, 1'b0);
    put_byte(8'h7F, 1'b1);
    put_seq(21'h80, 2, 2, 1'b0);
    put_seq(21'h800, 3, 3, 1'b0);
    put_seq(21'h10FFFF, 4, 4, 1'b1);
    put_seq(21'h7F, 2, 2, 1'b1);        // overlong
    put_seq(21'hDFFF, 3, 3, 1'b1);      // surrogate
    put_seq(21'h110000, 4, 4, 1'b1);    // above the last code point
    put_seq(21'h20AC, 3, 2, 1'b1);      // cut off by buffer end
    put_byte(8'hC3, 1'b0);
    put_byte(8'h41, 1'b1);
    put_byte(8'h80, 1'b0);              // stray continuation, rest of buffer dropped
    put_byte(8'h41, 1'b0);
    put_byte(8'hFF, 1'b1);
    put_byte(8'hFF, 1'b1);
    settle();

    set_mode(1'b1);
    put_seq(21'h10000, 4, 4, 1'b0);
    put_seq(21'hFFFF, 3, 3, 1'b0);
    put_seq(21'h10FFFF, 4, 4, 1'b1);
    rx_hold = 300;
    put_random(480);
    settle();

    set_mode(1'b0);
    rx_idle_on = 1'b0;
    put_random(480);
    settle();

    set_mode(1'b1);
    tx_idle_on = 1'b0;
    put_random(480);
    settle();

    set_mode(1'b0);
    rx_idle_on = 1'b1;
    put_random(480);
    settle();

    repeat (20) @(negedge clk);
    if (units_due.size() != 0) note_fault("missing result", units_due[0], '0);
    if (mism_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
